// ----- sv/ptscan_pkg.sv -----
// Shared types and constants for the path token scanner.
// Used by ptscan_front, ptscan_cmdq, ptscan_back and path_token_scanner_unit.
package ptscan_pkg;

    // Token kinds
    localparam logic [3:0] K_EOF    = 4'd0;
    localparam logic [3:0] K_IDENT  = 4'd1;
    localparam logic [3:0] K_INT    = 4'd2;
    localparam logic [3:0] K_FLOAT  = 4'd3;
    localparam logic [3:0] K_STR    = 4'd4;
    localparam logic [3:0] K_ASSIGN = 4'd5;
    localparam logic [3:0] K_SLASH  = 4'd6;
    localparam logic [3:0] K_ARGBEG = 4'd7;
    localparam logic [3:0] K_ARGNXT = 4'd8;
    localparam logic [3:0] K_MINUS  = 4'd9;
    localparam logic [3:0] K_COMMA  = 4'd10;
    localparam logic [3:0] K_OTHER  = 4'd11;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One result item
    typedef struct packed {
        logic       is_text;
        logic [3:0] kind;
        logic [7:0] text_char;
    } res_t;

    // Work for the back part: one or two results from one character
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } cmd_t;

endpackage

// ----- sv/ptscan_front.sv -----
// Front part: accepts characters, tracks the scan mode and builds result commands.
// Depends on ptscan_pkg.
module ptscan_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [7:0]        char_code,
    output logic              q_wr,
    output ptscan_pkg::cmd_t  q_wdata
);
    import ptscan_pkg::*;

    typedef enum logic [9:0] {
        M_IDLE  = 10'b00_0000_0001,
        M_IDENT = 10'b00_0000_0010,
        M_ZERO  = 10'b00_0000_0100,
        M_DEC   = 10'b00_0000_1000,
        M_HEX   = 10'b00_0001_0000,
        M_FRAC  = 10'b00_0010_0000,
        M_EXP0  = 10'b00_0100_0000,
        M_EXPD  = 10'b00_1000_0000,
        M_STR   = 10'b01_0000_0000,
        M_ESC   = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  emit;
        res_t  res;
    } start_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    function automatic logic f_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_hex(input logic [7:0] c);
        return f_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic f_expmark(input logic [7:0] c);
        return c == CH_E_LO || c == CH_E_UP;
    endfunction

    // Scan one character from the between-tokens mode
    function automatic start_t f_start(input logic [7:0] c);
        start_t s;
        s.mode = M_IDLE;
        s.emit = 1'b1;
        s.res  = '{is_text: 1'b0, kind: K_OTHER, text_char: c};
        if (c == CH_NUL) begin
            s.res.kind      = K_EOF;
        end else if (f_space(c)) begin
            s.emit = 1'b0;
        end else if (f_alpha(c)) begin
            s.mode = M_IDENT;
            s.res  = '{is_text: 1'b1, kind: K_IDENT, text_char: c};
        end else if (f_digit(c)) begin
            s.mode = (c == CH_ZERO) ? M_ZERO : M_DEC;
            s.res  = '{is_text: 1'b1, kind: K_INT, text_char: c};
        end else if (c == CH_QUOTE) begin
            s.mode = M_STR;
            s.emit = 1'b0;
        end else begin
            case (c)
                8'h3D:   s.res.kind = K_ASSIGN;
                8'h2F:   s.res.kind = K_SLASH;
                8'h3F:   s.res.kind = K_ARGBEG;
                8'h26:   s.res.kind = K_ARGNXT;
                8'h2D:   s.res.kind = K_MINUS;
                8'h2C:   s.res.kind = K_COMMA;
                default: s.res.kind = K_OTHER;
            endcase
        end
        return s;
    endfunction

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    logic       rescan;
    logic [3:0] ended;
    start_t     st;
    logic       accept;

    assign accept = push && !full;

    // Classify the character against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        cnt       = 2'd0;
        r0        = '0;
        r1        = '0;
        rescan    = 1'b0;
        ended     = K_EOF;
        st        = f_start(char_code);
        unique case (mode_reg)
            M_IDENT:
            begin
                if (f_alpha(char_code) || f_digit(char_code)) begin
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b1, kind: K_IDENT, text_char: char_code};
                end else begin
                    rescan = 1'b1;
                    ended  = K_IDENT;
                end
            end
            M_ZERO, M_DEC:
            begin
                cnt = 2'd1;
                if (mode_reg == M_ZERO && char_code == CH_X) begin
                    mode_next = M_HEX;
                    r0 = '{is_text: 1'b1, kind: K_INT, text_char: char_code};
                end else if (f_digit(char_code)) begin
                    mode_next = M_DEC;
                    r0 = '{is_text: 1'b1, kind: K_INT, text_char: char_code};
                end else if (char_code == CH_DOT) begin
                    mode_next = M_FRAC;
                    r0 = '{is_text: 1'b1, kind: K_FLOAT, text_char: char_code};
                end else if (f_expmark(char_code)) begin
                    mode_next = M_EXP0;
                    r0 = '{is_text: 1'b1, kind: K_FLOAT, text_char: char_code};
                end else begin
                    cnt    = 2'd0;
                    rescan = 1'b1;
                    ended  = K_INT;
                end
            end
            M_HEX:
            begin
                if (f_hex(char_code)) begin
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b1, kind: K_INT, text_char: char_code};
                end else begin
                    rescan = 1'b1;
                    ended  = K_INT;
                end
            end
            M_FRAC:
            begin
                cnt = 2'd1;
                if (f_digit(char_code)) begin
                    r0 = '{is_text: 1'b1, kind: K_FLOAT, text_char: char_code};
                end else if (f_expmark(char_code)) begin
                    mode_next = M_EXP0;
                    r0 = '{is_text: 1'b1, kind: K_FLOAT, text_char: char_code};
                end else begin
                    cnt    = 2'd0;
                    rescan = 1'b1;
                    ended  = K_FLOAT;
                end
            end
            M_EXP0, M_EXPD:
            begin
                if (f_digit(char_code) || (mode_reg == M_EXP0 && char_code == 8'h2D)) begin
                    mode_next = M_EXPD;
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b1, kind: K_FLOAT, text_char: char_code};
                end else begin
                    rescan = 1'b1;
                    ended  = K_FLOAT;
                end
            end
            M_STR:
            begin
                if (char_code == CH_NUL) begin
                    mode_next = M_IDLE;
                    cnt = 2'd2;
                    r0  = '{is_text: 1'b0, kind: K_STR, text_char: 8'h00};
                    r1  = '{is_text: 1'b0, kind: K_EOF, text_char: 8'h00};
                end else if (char_code == CH_QUOTE) begin
                    mode_next = M_IDLE;
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b0, kind: K_STR, text_char: 8'h00};
                end else if (char_code == CH_BSL) begin
                    mode_next = M_ESC;
                end else begin
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b1, kind: K_STR, text_char: char_code};
                end
            end
            M_ESC:
            begin
                if (char_code == CH_NUL) begin
                    mode_next = M_IDLE;
                    cnt = 2'd2;
                    r0  = '{is_text: 1'b0, kind: K_STR, text_char: 8'h00};
                    r1  = '{is_text: 1'b0, kind: K_EOF, text_char: 8'h00};
                end else begin
                    mode_next = M_STR;
                    cnt = 2'd1;
                    r0  = '{is_text: 1'b1, kind: K_STR,
                            text_char: (char_code == CH_N) ? CH_LF : char_code};
                end
            end
            M_IDLE:
            begin
                mode_next = st.mode;
                cnt       = {1'b0, st.emit};
                r0        = st.res;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        // Close the running token, then rescan the character from idle
        if (rescan) begin
            mode_next = st.mode;
            r0        = '{is_text: 1'b0, kind: ended, text_char: 8'h00};
            r1        = st.res;
            cnt       = st.emit ? 2'd2 : 2'd1;
        end
    end

    assign q_wr         = accept && (cnt != 2'd0);
    assign q_wdata.two  = (cnt == 2'd2);
    assign q_wdata.r0   = r0;
    assign q_wdata.r1   = r1;

    // Advance the scan mode on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

`ifndef SYNTHESIS
    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_code == CH_NUL) |=> (mode_reg == M_IDLE))
        else $error("mode not idle after end of text");

    a_eof_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_code == CH_NUL) |-> q_wr)
        else $error("end of text produced no command");
`endif

endmodule

// ----- sv/ptscan_cmdq.sv -----
// Short command queue that decouples the front and back parts.
// Depends on ptscan_pkg.
module ptscan_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  ptscan_pkg::cmd_t  wdata,
    output logic              full,
    input  logic              rd,
    output ptscan_pkg::cmd_t  rdata,
    output logic              empty
);
    import ptscan_pkg::*;

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wptr_reg;
    logic [QAW-1:0] rptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem[wptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && empty))
        else $error("command queue read while empty");
`endif

endmodule

// ----- sv/ptscan_back.sv -----
// Back part: expands each command into one or two results behind an output register.
// Depends on ptscan_pkg.
module ptscan_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ptscan_pkg::cmd_t  q_rdata,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output ptscan_pkg::res_t  out_res,
    output logic              out_last
);
    import ptscan_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic phase_reg;
    logic phase_next;
    res_t res_reg;
    res_t res_next;
    logic last_reg;
    logic last_next;
    logic load;

    assign load = !out_valid_reg || pop;

    // Pick the next result from the head command
    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        phase_next     = phase_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        q_rd           = 1'b0;
        if (load && !q_empty) begin
            out_valid_next = 1'b1;
            if (phase_reg) begin
                res_next   = q_rdata.r1;
                last_next  = 1'b1;
                phase_next = 1'b0;
                q_rd       = 1'b1;
            end else begin
                res_next   = q_rdata.r0;
                last_next  = !q_rdata.two;
                phase_next = q_rdata.two;
                q_rd       = !q_rdata.two;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_res  = res_reg;
    assign out_last = last_reg;

`ifndef SYNTHESIS
    a_phase_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_empty)
        else $error("second result pending without a queued command");

    a_text_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.is_text) |-> last_reg)
        else $error("text result not marked last of run");
`endif

endmodule

// ----- sv/path_token_scanner_unit.sv -----
// Path token scanner, top level: front classifier, command queue, result back end.
// Each result is written into the command queue, then loaded into the output register.
// Throughput: one character per cycle while the queue is not full; results leave at one per
// cycle while pop is high, set by the single output register, which holds two results in turn.
// Reset (rst_n, asynchronous, active low): scan mode idle, queue and output empty.
module path_token_scanner_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       pop,
    output logic       empty,
    output logic       is_text,
    output logic [3:0] kind,
    output logic [7:0] text_char,
    output logic       last_of_run
);
    import ptscan_pkg::*;

    logic q_wr;
    cmd_t q_wdata;
    logic q_rd;
    cmd_t q_rdata;
    logic q_empty;
    res_t out_res;

    ptscan_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata)
    );

    ptscan_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ptscan_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_res  (out_res),
        .out_last (last_of_run)
    );

    assign is_text   = out_res.is_text;
    assign kind      = out_res.kind;
    assign text_char = out_res.text_char;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for path_token_scanner_unit: character stream in, token results out.
// Depends on ptscan_pkg (token kind codes) and the scanner RTL; needs no other files.
`timescale 1ns / 100ps

module tb;

    import ptscan_pkg::*;

    // Scan modes of the tokenizer, mirrored for prediction
    typedef enum logic [3:0] {
        SM_IDLE, SM_IDENT, SM_ZERO, SM_DEC, SM_HEX,
        SM_FRAC, SM_EXP0, SM_EXPD, SM_STR, SM_ESC
    } scan_mode_e;

    // One expected result, including the end-of-step mark
    typedef struct packed {
        logic       is_text;
        logic [3:0] kind;
        logic [7:0] text_char;
        logic       last_mark;
    } token_res_t;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam int RANDOM_ITEMS = 800;
    localparam int PAUSE_AT     = 500;   // sender waits for a drained scanner here
    localparam int HOLD_AT      = 200;   // receiver starts its long hold-off here
    localparam int HOLD_CYCLES  = 80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] char_code = 8'h00;
    logic       pop = 1'b0;
    logic       empty;
    logic       is_text;
    logic [3:0] kind;
    logic [7:0] text_char;
    logic       last_of_run;

    logic [7:0] chars_to_send[$];
    token_res_t results_due[$];
    token_res_t step_res[$];
    scan_mode_e scan_mode = SM_IDLE;

    int n_sent = 0;
    int n_results = 0;
    int n_tokens = 0;
    int n_errors = 0;

    path_token_scanner_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_code   (char_code),
        .pop         (pop),
        .empty       (empty),
        .is_text     (is_text),
        .kind        (kind),
        .text_char   (text_char),
        .last_of_run (last_of_run)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hexdigit(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [3:0] mark_kind(logic [7:0] c);
        case (c)
            "=":     return K_ASSIGN;
            "/":     return K_SLASH;
            "?":     return K_ARGBEG;
            "&":     return K_ARGNXT;
            "-":     return K_MINUS;
            ",":     return K_COMMA;
            default: return K_OTHER;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic void add_res(logic t, logic [3:0] k, logic [7:0] ch);
        token_res_t r;
        r.is_text   = t;
        r.kind      = k;
        r.text_char = ch;
        r.last_mark = 1'b0;
        step_res.push_back(r);
    endfunction

    // Begin a new token from the idle mode
    function automatic void scan_from_idle(logic [7:0] c);
        scan_mode = SM_IDLE;
        if (c == CH_NUL)
            add_res(1'b0, K_EOF, 8'h00);
        else if (is_letter(c))
        begin
            scan_mode = SM_IDENT;
            add_res(1'b1, K_IDENT, c);
        end
        else if (is_digit(c))
        begin
            scan_mode = (c == "0") ? SM_ZERO : SM_DEC;
            add_res(1'b1, K_INT, c);
        end
        else if (c == "\"")
            scan_mode = SM_STR;
        else if (!is_blank(c))
            add_res(1'b0, mark_kind(c), c);
    endfunction

    // Advance the scan mode by one character and queue the results it yields
    function automatic void scan_char(logic [7:0] c);
        bit         closes;
        logic [3:0] closed_kind;
        closes = 1'b0;
        closed_kind = K_EOF;
        step_res.delete();
        case (scan_mode)
            SM_IDENT:
                if (is_letter(c) || is_digit(c))
                    add_res(1'b1, K_IDENT, c);
                else
                begin
                    closes = 1'b1;
                    closed_kind = K_IDENT;
                end
            SM_ZERO, SM_DEC:
                if (scan_mode == SM_ZERO && c == "x")
                begin
                    scan_mode = SM_HEX;
                    add_res(1'b1, K_INT, c);
                end
                else if (is_digit(c))
                begin
                    scan_mode = SM_DEC;
                    add_res(1'b1, K_INT, c);
                end
                else if (c == ".")
                begin
                    scan_mode = SM_FRAC;
                    add_res(1'b1, K_FLOAT, c);
                end
                else if (c == "e" || c == "E")
                begin
                    scan_mode = SM_EXP0;
                    add_res(1'b1, K_FLOAT, c);
                end
                else
                begin
                    closes = 1'b1;
                    closed_kind = K_INT;
                end
            SM_HEX:
                if (is_hexdigit(c))
                    add_res(1'b1, K_INT, c);
                else
                begin
                    closes = 1'b1;
                    closed_kind = K_INT;
                end
            SM_FRAC:
                if (is_digit(c))
                    add_res(1'b1, K_FLOAT, c);
                else if (c == "e" || c == "E")
                begin
                    scan_mode = SM_EXP0;
                    add_res(1'b1, K_FLOAT, c);
                end
                else
                begin
                    closes = 1'b1;
                    closed_kind = K_FLOAT;
                end
            SM_EXP0, SM_EXPD:
                if (is_digit(c) || (scan_mode == SM_EXP0 && c == "-"))
                begin
                    scan_mode = SM_EXPD;
                    add_res(1'b1, K_FLOAT, c);
                end
                else
                begin
                    closes = 1'b1;
                    closed_kind = K_FLOAT;
                end
            SM_STR:
                if (c == CH_NUL)
                begin
                    add_res(1'b0, K_STR, 8'h00);
                    scan_from_idle(c);
                end
                else if (c == "\"")
                begin
                    scan_mode = SM_IDLE;
                    add_res(1'b0, K_STR, 8'h00);
                end
                else if (c == "\\")
                    scan_mode = SM_ESC;
                else
                    add_res(1'b1, K_STR, c);
            SM_ESC:
                if (c == CH_NUL)
                begin
                    add_res(1'b0, K_STR, 8'h00);
                    scan_from_idle(c);
                end
                else
                begin
                    scan_mode = SM_STR;
                    add_res(1'b1, K_STR, (c == "n") ? CH_LF : c);
                end
            default:
                scan_from_idle(c);
        endcase
        // A character that ends a token is scanned again from idle
        if (closes)
        begin
            add_res(1'b0, closed_kind, 8'h00);
            scan_from_idle(c);
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last_mark = 1'b1;
        foreach (step_res[i])
            results_due.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        chars_to_send.push_back(b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            chars_to_send.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        else if (r < 16)
            return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return " ";
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            add_byte(rand_digit());
    endtask

    task automatic add_string_token();
        logic [7:0] b;
        add_byte("\"");
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                add_byte("\\");
                case ($urandom_range(0, 3))
                    0:       add_byte("n");
                    1:       add_byte("\"");
                    2:       add_byte("\\");
                    default: add_byte(8'($urandom_range(1, 255)));
                endcase
            end
            else
            begin
                do
                    b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(32, 126));
                while (b == "\"" || b == "\\");
                add_byte(b);
            end
        end
        // Leave a few strings open so the next token runs on inside them
        if ($urandom_range(0, 9) != 0)
            add_byte("\"");
    endtask

    task automatic add_float_token();
        int shape;
        shape = $urandom_range(0, 2);
        add_digits(1, 3);
        if (shape != 1)
        begin
            add_byte(".");
            add_digits(0, 3);
        end
        if (shape != 0)
        begin
            add_byte($urandom_range(0, 1) ? "e" : "E");
            if ($urandom_range(0, 1))
                add_byte("-");
            add_digits(0, 3);
        end
    endtask

    // Well-formed tokens with random content, mixed with broken numbers and noise
    task automatic load_random();
        int  pick;
        string marks;
        string breakers;
        marks = "=/?&-,";
        breakers = "xeE.-";
        while (chars_to_send.size() < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                add_byte(rand_letter());
                repeat ($urandom_range(0, 7))
                    add_byte($urandom_range(0, 2) ? rand_letter() : rand_digit());
            end
            else if (pick < 35)
                add_digits(1, 6);
            else if (pick < 43)
            begin
                add_text("0x");
                repeat ($urandom_range(1, 4))
                    add_byte(rand_hex());
            end
            else if (pick < 58)
                add_float_token();
            else if (pick < 70)
                add_string_token();
            else if (pick < 80)
                add_byte(marks[$urandom_range(0, 5)]);
            else if (pick < 86)
            begin
                add_digits(0, 2);
                add_byte(breakers[$urandom_range(0, 4)]);
                add_byte(8'($urandom_range(1, 255)));
            end
            else if (pick < 90)
                add_byte(CH_NUL);
            else
                add_byte(8'($urandom_range(0, 255)));
            // Separate tokens with whitespace, or let them run together
            if ($urandom_range(0, 9) < 6)
                repeat ($urandom_range(1, 2))
                    add_byte(rand_blank());
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------
    bit pausing = 1'b0;
    bit pause_done = 1'b0;

    always @(posedge clk)
    begin
        bit go;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            // Predict on each accepted transfer
            if (push && !full)
            begin
                scan_char(chars_to_send.pop_front());
                n_sent++;
            end
            if (!pause_done && n_sent >= PAUSE_AT)
            begin
                pausing = 1'b1;
                pause_done = 1'b1;
            end
            if (pausing && results_due.size() == 0 && empty)
                pausing = 1'b0;
            go = chars_to_send.size() > 0 && !pausing &&
                 ((n_sent >= 300 && n_sent < 420) || $urandom_range(0, 99) >= 38);
            push <= go;
            char_code <= go ? chars_to_send[0] : 8'($urandom_range(0, 255));
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        token_res_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            // Compare each transfer with the oldest expected result
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d char %02h",
                                              kind, text_char));
                else
                begin
                    want = results_due.pop_front();
                    if (is_text !== want.is_text)
                        report_mismatch($sformatf("result %0d: is_text %b, want %b",
                                                  n_results, is_text, want.is_text));
                    if (kind !== want.kind)
                        report_mismatch($sformatf("result %0d: kind %0d, want %0d",
                                                  n_results, kind, want.kind));
                    if (text_char !== want.text_char)
                        report_mismatch($sformatf("result %0d: text_char %02h, want %02h",
                                                  n_results, text_char, want.text_char));
                    if (last_of_run !== want.last_mark)
                        report_mismatch($sformatf("result %0d: last_of_run %b, want %b",
                                                  n_results, last_of_run, want.last_mark));
                    if (!want.is_text)
                        n_tokens++;
                end
                n_results++;
            end
            // Hold off once for a long stretch so the scanner backs up
            if (!hold_done && n_results >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= (n_results >= 350 && n_results < 500) || $urandom_range(0, 99) >= 38;
        end
    end

    // ------------------------------------------------------------------
    // Sequence and verdict
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: identifiers, hex, float with signed exponent, escapes,
        // end of text inside an escape, every mark, a high byte, whitespace, eof
        add_text("_z9?");
        add_text("0xAf.");
        add_text("1.5e-7&");
        add_text("\"\\n\\");
        add_byte(CH_NUL);
        add_text("=/-,");
        add_byte(8'hFF);
        add_byte(CH_TAB);
        add_byte(CH_NUL);
        load_random();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_to_send.size() != 0 || push)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Scanned %0d characters into %0d results, %0d of them token completions.",
                 n_sent, n_results, n_tokens);
        $display("Covered back-pressure hold, drained pause and %0d mismatches.", n_errors);
        if (n_errors == 0)
            $display("path_token_scanner_unit regression: pass");
        else
            $display("path_token_scanner_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Timed out with %0d results outstanding.", results_due.size());
        $display("path_token_scanner_unit regression: fail");
        $finish;
    end

endmodule
